/* design/snfi_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// snfi_pkg
// Types, codes and helpers shared by the shunting neural field integrator.
// ----------------------------------------------------------------------------
package snfi_pkg;

  localparam int DW = 32;

  typedef enum logic [1:0] {
    ACT_WEIGHT = 2'd0,
    ACT_EXCITE = 2'd1,
    ACT_RUN    = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    REG_NODES = 3'd0,
    REG_DECAY = 3'd1,
    REG_BOUND = 3'd2,
    REG_DT    = 3'd3,
    REG_MAXIT = 3'd4,
    REG_TOL   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]    action;
    logic [5:0]    row_index;
    logic [5:0]    col_index;
    logic [DW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [5:0]    node_index;
    logic [DW-1:0] activity;
    logic [15:0]   steps_taken;
    logic          converged;
    logic          last;
  } out_item_t;

  typedef struct packed {
    logic [6:0]    node_count;
    logic [DW-1:0] decay_rate;
    logic [DW-1:0] upper_bound;
    logic [DW-1:0] time_step;
    logic [15:0]   max_iterations;
    logic [DW-1:0] tolerance;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC_RD,
    ST_MAC_MUL,
    ST_MAC_ACC,
    ST_NODE_RD,
    ST_NODE_DRV,
    ST_NODE_GMUL,
    ST_NODE_DMUL,
    ST_NODE_DIF,
    ST_NODE_MMUL,
    ST_NODE_UPD,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT
  } state_t;

  // Q16.16 product back to Q16.16, saturating at all ones.
  function automatic logic [DW-1:0] qsat(input logic [2*DW-1:0] p);
    if (|p[2*DW-1:DW+16]) begin
      qsat = '1;
    end else begin
      qsat = p[DW+15:16];
    end
  endfunction

  function automatic logic [DW-1:0] sat_add(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic [DW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[DW]) begin
      sat_add = '1;
    end else begin
      sat_add = s[DW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

/* design/shunting_neural_field_integrator_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shunting_neural_field_integrator_top
// Shunting neural field integrator: weight and excitation loads, Euler runs.
// ----------------------------------------------------------------------------
// A weight or excitation write item is taken without leaving the idle state.
// A run item clears the activities and integrates with one shared 32 by 32
// multiplier: each node of a step takes a read, multiply and accumulate for
// every node of the field, then the update states. The run ends with N result
// items, each read, loaded and held until the sink is ready.
// The block takes no new item until the last result of a run has been taken.
module shunting_neural_field_integrator_top #(
  parameter int MAX_NODES = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [4:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire snfi_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output snfi_pkg::out_item_t      out_data
);
  import snfi_pkg::*;

  cfg_t cfg;

  snfi_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  snfi_core #(.MAX_NODES(MAX_NODES)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* design/snfi_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// snfi_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module snfi_regs (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [4:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic      [31:0]    prdata,
  output logic                pready,
  output snfi_pkg::cfg_t      cfg
);
  import snfi_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_count     <= 7'd2;
      cfg_r.decay_rate     <= 32'd65536;
      cfg_r.upper_bound    <= 32'd65536;
      cfg_r.time_step      <= 32'd655;
      cfg_r.max_iterations <= 16'd1000;
      cfg_r.tolerance      <= 32'd1;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_NODES: cfg_r.node_count     <= pwdata[6:0];
        REG_DECAY: cfg_r.decay_rate     <= pwdata;
        REG_BOUND: cfg_r.upper_bound    <= pwdata;
        REG_DT:    cfg_r.time_step      <= pwdata;
        REG_MAXIT: cfg_r.max_iterations <= pwdata[15:0];
        REG_TOL:   cfg_r.tolerance      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_NODES: prdata = {25'd0, cfg_r.node_count};
      REG_DECAY: prdata = cfg_r.decay_rate;
      REG_BOUND: prdata = cfg_r.upper_bound;
      REG_DT:    prdata = cfg_r.time_step;
      REG_MAXIT: prdata = {16'd0, cfg_r.max_iterations};
      REG_TOL:   prdata = cfg_r.tolerance;
      default:   prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* design/snfi_mul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// snfi_mul
// Shared 32 by 32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module snfi_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] prod
);
  logic [63:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= {32'd0, a} * {32'd0, b};
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

/* design/snfi_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// snfi_core
// Sequencer, stores and datapath of the Euler integrator around one multiplier.
// ----------------------------------------------------------------------------
module snfi_core #(
  parameter int MAX_NODES = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire snfi_pkg::cfg_t      cfg,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire snfi_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output snfi_pkg::out_item_t      out_data
);
  import snfi_pkg::*;

  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int WD = MAX_NODES * MAX_NODES;
  localparam int AW = $clog2(WD);

  state_t state_r, state_nxt;

  logic [CW-1:0] n_r, i_r, j_r;
  logic [15:0]   steps_r;
  logic          conv_r, first_r, bank_r;
  logic [31:0]   lat_r, drive_r, x_r, gain_r, decay_r, worst_r;
  logic          out_valid_r;
  out_item_t     out_r;

  // Stores.
  logic [31:0] wmem [WD];
  logic [31:0] emem [MAX_NODES];
  logic [31:0] act0 [MAX_NODES];
  logic [31:0] act1 [MAX_NODES];
  logic [31:0] w_q, e_q, a0_q, a1_q;

  logic          accept, w_we, e_we, a_we;
  logic [AW-1:0] w_waddr, w_raddr;
  logic [NW-1:0] a_raddr, row_lo, col_lo;
  logic [31:0]   x_q, nx, change, move, mag, mul_a, mul_b;
  logic [63:0]   prod;
  logic [32:0]   up_sum;
  logic          rising, step_end, row_ok, col_ok;
  logic [CW-1:0] n_eff;
  logic [15:0]   steps_inc;

  assign accept = in_valid && in_ready;
  assign row_lo = in_data.row_index[NW-1:0];
  assign col_lo = in_data.col_index[NW-1:0];
  assign row_ok = {1'b0, in_data.row_index} < 7'(MAX_NODES);
  assign col_ok = {1'b0, in_data.col_index} < 7'(MAX_NODES);
  assign w_we   = accept && (in_data.action == ACT_WEIGHT) && row_ok && col_ok;
  assign e_we   = accept && (in_data.action == ACT_EXCITE) && row_ok;
  assign w_waddr = AW'(row_lo) * AW'(MAX_NODES) + AW'(col_lo);
  assign w_raddr = AW'(i_r[NW-1:0]) * AW'(MAX_NODES) + AW'(j_r[NW-1:0]);
  assign a_raddr = (state_r == ST_MAC_RD) ? j_r[NW-1:0] : i_r[NW-1:0];
  assign a_we    = (state_r == ST_NODE_UPD);

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= in_data.value;
    end
    w_q <= wmem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      emem[row_lo] <= in_data.value;
    end
    e_q <= emem[i_r[NW-1:0]];
  end

  // Next activities go to the bank that is not being read this step.
  always_ff @(posedge clk) begin
    if (a_we && bank_r) begin
      act0[i_r[NW-1:0]] <= nx;
    end
    a0_q <= act0[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (a_we && !bank_r) begin
      act1[i_r[NW-1:0]] <= nx;
    end
    a1_q <= act1[a_raddr];
  end

  // Before the first step ends every activity is zero, whatever the banks hold.
  assign x_q = first_r ? 32'd0 : (bank_r ? a1_q : a0_q);

  // Shared multiplier operand selection.
  always_comb begin
    case (state_r)
      ST_MAC_MUL:   begin mul_a = w_q;                       mul_b = x_q;     end
      ST_NODE_GMUL: begin mul_a = cfg.upper_bound - x_r;     mul_b = drive_r; end
      ST_NODE_DMUL: begin mul_a = cfg.decay_rate;            mul_b = x_r;     end
      default:      begin mul_a = cfg.time_step;             mul_b = mag;     end
    endcase
  end

  snfi_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign rising = gain_r >= decay_r;
  assign mag    = rising ? gain_r - decay_r : decay_r - gain_r;
  assign move   = qsat(prod);
  assign up_sum = {1'b0, x_r} + {1'b0, move};

  always_comb begin
    if (rising) begin
      nx = (up_sum > {1'b0, cfg.upper_bound}) ? cfg.upper_bound : up_sum[31:0];
    end else begin
      nx = (move >= x_r) ? 32'd0 : x_r - move;
    end
    change = (nx >= x_r) ? nx - x_r : x_r - nx;
  end

  always_comb begin
    if (cfg.node_count == 7'd0) begin
      n_eff = CW'(1);
    end else if (cfg.node_count > 7'(MAX_NODES)) begin
      n_eff = CW'(MAX_NODES);
    end else begin
      n_eff = CW'(cfg.node_count);
    end
  end

  assign step_end  = (i_r == n_r - CW'(1));
  assign steps_inc = steps_r + 16'd1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_data.action == ACT_RUN) begin
          state_nxt = (cfg.max_iterations == 16'd0) ? ST_OUT_RD : ST_MAC_RD;
        end
      end
      ST_MAC_RD:    state_nxt = ST_MAC_MUL;
      ST_MAC_MUL:   state_nxt = ST_MAC_ACC;
      ST_MAC_ACC:   state_nxt = (j_r == n_r - CW'(1)) ? ST_NODE_RD : ST_MAC_RD;
      ST_NODE_RD:   state_nxt = ST_NODE_DRV;
      ST_NODE_DRV:  state_nxt = ST_NODE_GMUL;
      ST_NODE_GMUL: state_nxt = ST_NODE_DMUL;
      ST_NODE_DMUL: state_nxt = ST_NODE_DIF;
      ST_NODE_DIF:  state_nxt = ST_NODE_MMUL;
      ST_NODE_MMUL: state_nxt = ST_NODE_UPD;
      ST_NODE_UPD: begin
        if (!step_end) begin
          state_nxt = ST_MAC_RD;
        end else begin
          if ((((change > worst_r) ? change : worst_r) < cfg.tolerance) ||
              (steps_inc == cfg.max_iterations)) begin
            state_nxt = ST_OUT_RD;
          end else begin
            state_nxt = ST_MAC_RD;
          end
        end
      end
      ST_OUT_RD:    state_nxt = ST_OUT_LD;
      ST_OUT_LD:    state_nxt = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (out_ready) begin
          state_nxt = (i_r == n_r - CW'(1)) ? ST_IDLE : ST_OUT_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      first_r     <= 1'b1;
      bank_r      <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      n_r         <= CW'(1);
      steps_r     <= '0;
      conv_r      <= 1'b0;
      worst_r     <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (accept && in_data.action == ACT_RUN) begin
            n_r     <= n_eff;
            i_r     <= '0;
            j_r     <= '0;
            steps_r <= '0;
            conv_r  <= 1'b0;
            first_r <= 1'b1;
            worst_r <= '0;
            lat_r   <= '0;
          end
        end
        ST_MAC_ACC: begin
          lat_r <= sat_add(lat_r, qsat(prod));
          j_r   <= j_r + CW'(1);
        end
        ST_NODE_DRV: begin
          x_r     <= x_q;
          drive_r <= sat_add(e_q, lat_r);
        end
        ST_NODE_DMUL: gain_r  <= qsat(prod);
        ST_NODE_DIF:  decay_r <= qsat(prod);
        ST_NODE_UPD: begin
          j_r   <= '0;
          lat_r <= '0;
          if (!step_end) begin
            i_r     <= i_r + CW'(1);
            worst_r <= (change > worst_r) ? change : worst_r;
          end else begin
            i_r     <= '0;
            worst_r <= '0;
            steps_r <= steps_inc;
            bank_r  <= ~bank_r;
            first_r <= 1'b0;
            conv_r  <= ((change > worst_r) ? change : worst_r) < cfg.tolerance;
          end
        end
        ST_OUT_LD: begin
          out_valid_r         <= 1'b1;
          out_r.node_index    <= 6'(i_r);
          out_r.activity      <= x_q;
          out_r.steps_taken   <= steps_r;
          out_r.converged     <= conv_r;
          out_r.last          <= (i_r == n_r - CW'(1));
        end
        ST_OUT_WAIT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            i_r         <= i_r + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

/* design/snfi_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// snfi_checker
// Port-level checks on the integrator, bound to the top level.
// ----------------------------------------------------------------------------
module snfi_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                pready,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire snfi_pkg::in_item_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire snfi_pkg::out_item_t out_data
);
  import snfi_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while a result is pending");

  a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.action != ACT_RUN) |=> in_ready)
    else $error("load item did not complete in one cycle");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

endmodule

bind shunting_neural_field_integrator_top snfi_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .pready    (pready),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

/* sim/tb_shunting_neural_field_integrator_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_shunting_neural_field_integrator_top
// Self-checking bench for the shunting neural field integrator. Weight and
// excitation loads and run items are sent over the input channel. A local
// Q16.16 integrator predicts each run's activities, which are checked against
// the result items. Register settings are changed between phases over APB.
// ----------------------------------------------------------------------------
module tb_shunting_neural_field_integrator_top;
  import snfi_pkg::*;

  localparam int NODES = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  shunting_neural_field_integrator_top #(.MAX_NODES(NODES)) u_dut (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #6 clk = ~clk;

  // Local copy of the block's state and registers.
  logic [31:0] weight_mem [NODES*NODES];
  logic [31:0] excite_mem [NODES];
  bit          weight_set [NODES*NODES];
  bit          excite_set [NODES];
  cfg_t        cfg_shadow;

  out_item_t   activity_q[$];
  int          errors = 0;
  bit          calm = 1'b0;

  function automatic logic [63:0] q_mul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = ({32'd0, a} * {32'd0, b}) >> 16;
    return (p > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : p;
  endfunction

  function automatic logic [63:0] s_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : s;
  endfunction

  // Integrates one run and queues the activities it should report.
  task automatic predict_run();
    logic [31:0] x [NODES];
    logic [31:0] xn [NODES];
    logic [63:0] lat, drive, gain, decay, mag, move, nx, chg, worst;
    int n, steps;
    bit conv;
    out_item_t r;
    n = cfg_shadow.node_count;
    if (n < 1) n = 1;
    if (n > NODES) n = NODES;
    for (int i = 0; i < NODES; i++) x[i] = '0;
    steps = 0;
    conv = 1'b0;
    while (steps < cfg_shadow.max_iterations) begin
      worst = 0;
      for (int i = 0; i < n; i++) begin
        lat = 0;
        for (int j = 0; j < n; j++) lat = s_add(lat, q_mul(weight_mem[i*NODES+j], x[j]));
        drive = s_add({32'd0, excite_mem[i]}, lat);
        gain  = q_mul(cfg_shadow.upper_bound - x[i], drive[31:0]);
        decay = q_mul(cfg_shadow.decay_rate, x[i]);
        mag   = (gain >= decay) ? gain - decay : decay - gain;
        move  = q_mul(cfg_shadow.time_step, mag[31:0]);
        if (gain >= decay) begin
          nx = x[i] + move;
          if (nx > cfg_shadow.upper_bound) nx = cfg_shadow.upper_bound;
        end else begin
          nx = (move >= x[i]) ? 0 : x[i] - move;
        end
        xn[i] = nx[31:0];
        chg = (nx >= x[i]) ? nx - x[i] : x[i] - nx;
        if (chg > worst) worst = chg;
      end
      for (int i = 0; i < n; i++) x[i] = xn[i];
      steps++;
      if (worst < cfg_shadow.tolerance) begin
        conv = 1'b1;
        break;
      end
    end
    for (int i = 0; i < n; i++) begin
      r.node_index  = i[5:0];
      r.activity    = x[i];
      r.steps_taken = steps[15:0];
      r.converged   = conv;
      r.last        = (i == n - 1);
      activity_q    = {activity_q, r};
    end
  endtask

  // Sends one item and updates the local state once it has been accepted.
  task automatic send_item(input in_item_t it);
    while (!calm && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    case (action_t'(it.action))
      ACT_WEIGHT: begin
        weight_mem[it.row_index*NODES+it.col_index] = it.value;
        weight_set[it.row_index*NODES+it.col_index] = 1'b1;
      end
      ACT_EXCITE: begin
        excite_mem[it.row_index] = it.value;
        excite_set[it.row_index] = 1'b1;
      end
      ACT_RUN: predict_run();
      default: ;
    endcase
  endtask

  task automatic load(input action_t a, input int row, input int col, input logic [31:0] v);
    in_item_t it;
    it.action = a;
    it.row_index = row[5:0];
    it.col_index = col[5:0];
    it.value = v;
    send_item(it);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return $urandom;
      default: return $urandom_range(0, 32'h0002_0000);
    endcase
  endfunction

  // Fills any entry the run would read, then sends the run item.
  task automatic start_run();
    int n;
    n = cfg_shadow.node_count;
    if (n < 1) n = 1;
    if (n > NODES) n = NODES;
    for (int i = 0; i < n; i++) begin
      if (!excite_set[i]) load(ACT_EXCITE, i, $urandom_range(0, 63), rand_value());
      for (int j = 0; j < n; j++)
        if (!weight_set[i*NODES+j]) load(ACT_WEIGHT, i, j, rand_value());
    end
    load(ACT_RUN, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (activity_q.size() != 0) @(posedge clk);
  endtask

  // Registers change only once the block has gone quiet.
  task automatic settle();
    wait_results();
    repeat (10) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t r, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (r)
      REG_NODES: cfg_shadow.node_count     = v[6:0];
      REG_DECAY: cfg_shadow.decay_rate     = v;
      REG_BOUND: cfg_shadow.upper_bound    = v;
      REG_DT:    cfg_shadow.time_step      = v;
      REG_MAXIT: cfg_shadow.max_iterations = v[15:0];
      REG_TOL:   cfg_shadow.tolerance      = v;
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [31:0] nodes, input logic [31:0] a, input logic [31:0] b,
                         input logic [31:0] dt, input logic [31:0] maxit,
                         input logic [31:0] tol);
    settle();
    cfg_write(REG_NODES, nodes);
    cfg_write(REG_DECAY, a);
    cfg_write(REG_BOUND, b);
    cfg_write(REG_DT, dt);
    cfg_write(REG_MAXIT, maxit);
    cfg_write(REG_TOL, tol);
  endtask

  // Field extremes on loads, including the unused action.
  task automatic test_load_extremes();
    load(ACT_WEIGHT, 0, 0, 32'h0);
    load(ACT_WEIGHT, 63, 63, 32'hFFFF_FFFF);
    load(ACT_WEIGHT, 0, 1, 32'h0000_8000);
    load(ACT_WEIGHT, 1, 0, 32'h0001_0000);
    load(ACT_WEIGHT, 1, 1, 32'h0000_4000);
    load(ACT_EXCITE, 0, 63, 32'h0000_8000);
    load(ACT_EXCITE, 1, 0, 32'h0001_0000);
    load(ACT_EXCITE, 63, 0, 32'hFFFF_FFFF);
    load(ACT_NONE, 63, 63, 32'hFFFF_FFFF);
    load(ACT_NONE, 0, 0, 32'h0);
  endtask

  // Run with the settings left by reset.
  task automatic test_reset_settings();
    start_run();
  endtask

  task automatic test_zero_limit();
    set_all(3, 32'h0001_0000, 32'h0001_0000, 32'h0000_8000, 0, 1);
    start_run();
  endtask

  // Tolerance of all ones, first with a limit of one step, then with a limit of 65535.
  task automatic test_final_step_convergence();
    set_all(2, 32'h0000_8000, 32'h0002_0000, 32'h0001_0000, 1, 32'hFFFF_FFFF);
    start_run();
    set_all(1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF, 32'hFFFF_FFFF);
    start_run();
  endtask

  // Zero tolerance never converges, so the limit ends these runs.
  task automatic test_saturation();
    set_all(2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5, 0);
    start_run();
    set_all(2, 0, 0, 32'h0001_0000, 3, 0);
    start_run();
  endtask

  task automatic test_node_count_extremes();
    set_all(0, 32'h0000_1000, 32'h0001_0000, 32'h0000_4000, 4, 32'h10);
    start_run();
    set_all(64, 32'h0001_0000, 32'h0001_0000, 32'h0000_2000, 2, 0);
    start_run();
    set_all(127, 32'h0001_0000, 32'h0004_0000, 32'h0001_0000, 1, 0);
    start_run();
  endtask

  task automatic test_random_phases();
    int pick, lim;
    for (int ph = 0; ph < 6; ph++) begin
      set_all($urandom_range(0, 6), rand_value(), rand_value(),
              ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0002_0000),
              $urandom_range(0, 40),
              ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 32'h400));
      calm = (ph == 2);
      for (int k = 0; k < 60; k++) begin
        pick = $urandom_range(0, 99);
        lim = ($urandom_range(0, 4) == 0) ? 63 : 7;
        if (pick < 45) load(ACT_WEIGHT, $urandom_range(0, lim), $urandom_range(0, lim),
                            rand_value());
        else if (pick < 75) load(ACT_EXCITE, $urandom_range(0, lim), $urandom_range(0, 63),
                                 rand_value());
        else if (pick < 95) begin
          start_run();
          if (ph == 0) wait_results();
        end else load(ACT_NONE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
      end
      calm = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 36);
  end

  // Each accepted result item is compared with the oldest prediction.
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (activity_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item %h", $time, out_data);
      end else begin
        e = activity_q.pop_front();
        if (e.node_index !== out_data.node_index) begin
          errors++;
          $display("%0t: node_index expected %0d got %0d", $time, e.node_index,
                   out_data.node_index);
        end
        if (e.activity !== out_data.activity) begin
          errors++;
          $display("%0t: activity expected %h got %h", $time, e.activity, out_data.activity);
        end
        if (e.steps_taken !== out_data.steps_taken) begin
          errors++;
          $display("%0t: steps_taken expected %0d got %0d", $time, e.steps_taken,
                   out_data.steps_taken);
        end
        if (e.converged !== out_data.converged) begin
          errors++;
          $display("%0t: converged expected %b got %b", $time, e.converged,
                   out_data.converged);
        end
        if (e.last !== out_data.last) begin
          errors++;
          $display("%0t: last expected %b got %b", $time, e.last, out_data.last);
        end
      end
    end
  end

  initial begin
    cfg_shadow = '{node_count: 7'd2, decay_rate: 32'd65536, upper_bound: 32'd65536,
                   time_step: 32'd655, max_iterations: 16'd1000, tolerance: 32'd1};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_load_extremes();
    test_reset_settings();
    test_zero_limit();
    test_final_step_convergence();
    test_saturation();
    test_node_count_extremes();
    test_random_phases();
    wait_results();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
design/snfi_pkg.sv
design/snfi_regs.sv
design/snfi_mul.sv
design/snfi_core.sv
design/shunting_neural_field_integrator_top.sv
design/snfi_checker.sv
sim/tb_shunting_neural_field_integrator_top.sv
